// File: src/bps_pkg.sv
// Shared types and constants for the beep pattern sequencer.
package bps_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int POS_W       = $clog2(TABLE_DEPTH + 1);
  localparam int MS_W        = 16;
  localparam int DIV_W       = 20;
  localparam logic [DIV_W-1:0] DIV_RESET = DIV_W'(1000);

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_START = 2'd2,
    CMD_STOP  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    STATUS_OK           = 2'd0,
    STATUS_INVALID_SIZE = 2'd1,
    STATUS_BUSY         = 2'd2
  } status_t;

  typedef struct packed {
    logic [1:0]      command;
    logic [IDX_W-1:0] entry_index;
    logic [MS_W-1:0] buzz_ms;
    logic [MS_W-1:0] quiet_ms;
    logic [4:0]      sound_count;
  } word_t;

  typedef struct packed {
    status_t          status;
    logic             buzzer_on;
    logic             busy_res;
    logic [POS_W-1:0] current_sound;
  } result_t;

endpackage

// File: src/beep_pattern_sequencer.sv
// Top level: input register, sequencer core, result register, divider register.
//
// Plays up to 16 stored sounds (on time, off time in milliseconds) on the
// buzzer pin. Every input word (tick, write entry, start, stop) yields one
// result word carrying status, pin level, busy flag and current sound index.
// One word is accepted per clock cycle while the output is not stalled; each
// word passes the input register, the combinational sequencer update and the
// result register. The sound table has no reset and needs no clearing pass;
// only entries written before a start are meaningful. ticks_per_msec resets
// to 1000 and is to be written with cfg_we only while the block is idle; the
// block itself does not enforce this. A value of 0 acts as 1.
module beep_pattern_sequencer (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [19:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  command,
  input  logic [3:0]  entry_index,
  input  logic [15:0] buzz_ms,
  input  logic [15:0] quiet_ms,
  input  logic [4:0]  sound_count,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic        buzzer_on,
  output logic        busy_res,
  output logic [4:0]  current_sound
);

  logic [bps_pkg::DIV_W-1:0] ticks_per_msec;
  logic                      in_full;
  bps_pkg::word_t            word;
  bps_pkg::result_t          result_comb;
  bps_pkg::result_t          result;
  logic                      advance;

  assign advance  = in_full && (!out_valid || out_ready);
  assign in_ready = !in_full || advance;

  // Hold the divider register
  always_ff @(posedge clk) begin
    if (rst) begin
      ticks_per_msec <= bps_pkg::DIV_RESET;
    end else if (cfg_we) begin
      ticks_per_msec <= cfg_wdata;
    end
  end

  // Capture the input word
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      word.command     <= command;
      word.entry_index <= entry_index;
      word.buzz_ms     <= buzz_ms;
      word.quiet_ms    <= quiet_ms;
      word.sound_count <= sound_count;
    end
  end

  bps_core u_core (
    .clk            (clk),
    .rst            (rst),
    .advance        (advance),
    .ticks_per_msec (ticks_per_msec),
    .word           (word),
    .result         (result_comb)
  );

  // Hold the result word until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= result_comb;
    end
  end

  assign status        = result.status;
  assign buzzer_on     = result.buzzer_on;
  assign busy_res      = result.busy_res;
  assign current_sound = result.current_sound;

endmodule

// File: src/bps_core.sv
// Sequencer state, sound table and per-word next-state logic.
module bps_core (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     advance,
  input  logic [bps_pkg::DIV_W-1:0] ticks_per_msec,
  input  bps_pkg::word_t           word,
  output bps_pkg::result_t         result
);

  localparam int IDX_W = bps_pkg::IDX_W;
  localparam int POS_W = bps_pkg::POS_W;
  localparam int MS_W  = bps_pkg::MS_W;
  localparam int DIV_W = bps_pkg::DIV_W;

  logic [2*MS_W-1:0] sound_table [bps_pkg::TABLE_DEPTH];

  logic [POS_W-1:0] list_length, list_length_next;
  logic [POS_W-1:0] sound_position, sound_position_next;
  logic             pin_high, pin_high_next;
  logic             playing_flag, playing_flag_next;
  logic [DIV_W-1:0] prescale_count, prescale_count_next;
  logic [MS_W-1:0]  msecs_left, msecs_left_next;

  logic [2*MS_W-1:0] entry;
  logic [DIV_W-1:0]  div;
  logic [DIV_W:0]    pre_inc;
  logic [MS_W-1:0]   ms_dec;
  logic [POS_W-1:0]  pos_inc;
  logic              expire;
  logic              table_we;
  bps_pkg::status_t  status;

  function automatic logic [MS_W-1:0] load_duration(input logic [MS_W-1:0] d);
    return (d == '0) ? MS_W'(1) : d;
  endfunction

  // Fetch the current entry and the counter arithmetic
  always_comb begin
    entry = '0;
    if (sound_position < POS_W'(bps_pkg::TABLE_DEPTH)) begin
      entry = sound_table[sound_position[IDX_W-1:0]];
    end
    div     = (ticks_per_msec == '0) ? DIV_W'(1) : ticks_per_msec;
    pre_inc = {1'b0, prescale_count} + (DIV_W+1)'(1);
    ms_dec  = msecs_left - MS_W'(1);
    pos_inc = sound_position + POS_W'(1);
  end

  // Decode the command and work out the next state
  always_comb begin
    list_length_next    = list_length;
    sound_position_next = sound_position;
    pin_high_next       = pin_high;
    playing_flag_next   = playing_flag;
    prescale_count_next = prescale_count;
    msecs_left_next     = msecs_left;
    status              = bps_pkg::STATUS_OK;
    expire              = 1'b0;
    table_we            = 1'b0;

    unique case (bps_pkg::cmd_t'(word.command))
      bps_pkg::CMD_TICK: begin
        if (playing_flag) begin
          if (msecs_left == '0) begin
            expire = 1'b1;
          end else if (pre_inc >= {1'b0, div}) begin
            prescale_count_next = '0;
            msecs_left_next     = ms_dec;
            if (ms_dec == '0) begin
              expire = 1'b1;
            end
          end else begin
            prescale_count_next = pre_inc[DIV_W-1:0];
          end
        end
      end
      bps_pkg::CMD_WRITE: begin
        if (playing_flag) begin
          status = bps_pkg::STATUS_BUSY;
        end else if ({1'b0, word.entry_index} < (IDX_W+1)'(bps_pkg::TABLE_DEPTH)) begin
          table_we = 1'b1;
        end
      end
      bps_pkg::CMD_START: begin
        if (word.sound_count == '0 ||
            word.sound_count > 5'(bps_pkg::TABLE_DEPTH)) begin
          status = bps_pkg::STATUS_INVALID_SIZE;
        end else if (playing_flag) begin
          status = bps_pkg::STATUS_BUSY;
        end else begin
          playing_flag_next   = 1'b1;
          list_length_next    = POS_W'(word.sound_count);
          sound_position_next = '0;
          pin_high_next       = 1'b0;
          prescale_count_next = '0;
          msecs_left_next     = '0;
        end
      end
      bps_pkg::CMD_STOP: begin
        pin_high_next       = 1'b0;
        playing_flag_next   = 1'b0;
        prescale_count_next = '0;
        msecs_left_next     = '0;
      end
      default: begin
      end
    endcase

    // Toggle the phase on expiry; end after the last on phase
    if (expire) begin
      prescale_count_next = '0;
      if (pin_high) begin
        pin_high_next       = 1'b0;
        msecs_left_next     = load_duration(entry[MS_W-1:0]);
        sound_position_next = pos_inc;
        if (pos_inc >= list_length) begin
          playing_flag_next = 1'b0;
          msecs_left_next   = '0;
        end
      end else begin
        pin_high_next   = 1'b1;
        msecs_left_next = load_duration(entry[2*MS_W-1:MS_W]);
      end
    end
  end

  // Build the result word
  always_comb begin
    result.status        = status;
    result.buzzer_on     = pin_high_next;
    result.busy_res      = playing_flag_next;
    result.current_sound = sound_position_next;
  end

  // Hold control state; advance once per processed word
  always_ff @(posedge clk) begin
    if (rst) begin
      list_length    <= '0;
      sound_position <= '0;
      pin_high       <= 1'b0;
      playing_flag   <= 1'b0;
      prescale_count <= '0;
      msecs_left     <= '0;
    end else if (advance) begin
      list_length    <= list_length_next;
      sound_position <= sound_position_next;
      pin_high       <= pin_high_next;
      playing_flag   <= playing_flag_next;
      prescale_count <= prescale_count_next;
      msecs_left     <= msecs_left_next;
    end
  end

  // Write a sound entry
  always_ff @(posedge clk) begin
    if (advance && table_we) begin
      sound_table[word.entry_index] <= {word.buzz_ms, word.quiet_ms};
    end
  end

endmodule

// File: tb/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for beep_pattern_sequencer with a cycle-free sequencer predictor.
module tb;

  localparam int TABLE_DEPTH  = bps_pkg::TABLE_DEPTH;
  localparam int IDX_W        = bps_pkg::IDX_W;
  localparam int POS_W        = bps_pkg::POS_W;
  localparam int MS_W         = bps_pkg::MS_W;
  localparam int DIV_W        = bps_pkg::DIV_W;
  localparam int HALF_PERIOD  = 6;
  localparam int RESET_CYCLES = 11;
  localparam int RANDOM_WORDS = 330;
  localparam int IDLE_LIMIT   = 4000;
  localparam int LONG_HOLD    = 300;
  localparam int PLAY_BUDGET  = 150;
  localparam int SLOW_BUDGET  = 20;

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   cfg_we;
  logic [DIV_W-1:0]       cfg_wdata;
  logic                   in_valid;
  logic                   in_ready;
  logic [1:0]             command;
  logic [IDX_W-1:0]       entry_index;
  logic [MS_W-1:0]        buzz_ms;
  logic [MS_W-1:0]        quiet_ms;
  logic [4:0]             sound_count;
  logic                   out_valid;
  logic                   out_ready;
  logic [1:0]             status;
  logic                   buzzer_on;
  logic                   busy_res;
  logic [POS_W-1:0]       current_sound;

  // Sequencer state as the predictor sees it
  logic [MS_W-1:0]        tone_on_ms  [TABLE_DEPTH];
  logic [MS_W-1:0]        tone_off_ms [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] tone_loaded;
  logic [POS_W-1:0]       seq_len;
  logic [POS_W-1:0]       seq_pos;
  logic                   pin_level;
  logic                   playing;
  logic [DIV_W-1:0]       prescale;
  logic [DIV_W-1:0]       divider;
  logic [MS_W-1:0]        ms_left;

  bps_pkg::result_t due_results [$];
  int      words_sent;
  int      results_seen;
  int      errors;
  int      idle_cycles;
  int      rx_stall;
  bit      steady_in;
  bit      steady_out;
  bit      hold_out_req;

  beep_pattern_sequencer i_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .command      (command),
    .entry_index  (entry_index),
    .buzz_ms      (buzz_ms),
    .quiet_ms     (quiet_ms),
    .sound_count  (sound_count),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .buzzer_on    (buzzer_on),
    .busy_res     (busy_res),
    .current_sound(current_sound)
  );

  always #(HALF_PERIOD) clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Close the running phase: toggle the pin, load the next duration, advance
  function automatic void end_phase();
    logic [MS_W-1:0] on_t;
    logic [MS_W-1:0] off_t;
    on_t  = '0;
    off_t = '0;
    if (seq_pos < TABLE_DEPTH) begin
      on_t  = tone_on_ms[seq_pos[IDX_W-1:0]];
      off_t = tone_off_ms[seq_pos[IDX_W-1:0]];
    end
    prescale = '0;
    if (pin_level) begin
      pin_level = 1'b0;
      ms_left   = (off_t == '0) ? MS_W'(1) : off_t;
      seq_pos   = seq_pos + 1'b1;
      // the last sound ends with its on phase
      if (seq_pos >= seq_len) begin
        playing = 1'b0;
        ms_left = '0;
      end
    end else begin
      pin_level = 1'b1;
      ms_left   = (on_t == '0) ? MS_W'(1) : on_t;
    end
  endfunction

  // Apply one accepted word to the state and return the result word it yields
  function automatic bps_pkg::result_t advance_sequencer(input bps_pkg::word_t w);
    bps_pkg::result_t r;
    logic [DIV_W-1:0] div_eff;
    div_eff  = (divider == '0) ? DIV_W'(1) : divider;
    r.status = bps_pkg::STATUS_OK;
    case (w.command)
      bps_pkg::CMD_TICK: begin
        if (playing) begin
          if (ms_left == '0) begin
            end_phase();
          end else begin
            prescale = prescale + 1'b1;
            if (prescale >= div_eff) begin
              prescale = '0;
              ms_left  = ms_left - 1'b1;
              if (ms_left == '0) end_phase();
            end
          end
        end
      end
      bps_pkg::CMD_WRITE: begin
        if (playing) begin
          r.status = bps_pkg::STATUS_BUSY;
        end else begin
          tone_on_ms[w.entry_index]  = w.buzz_ms;
          tone_off_ms[w.entry_index] = w.quiet_ms;
          tone_loaded[w.entry_index] = 1'b1;
        end
      end
      bps_pkg::CMD_START: begin
        // size is checked before the busy check
        if (w.sound_count == '0 || w.sound_count > TABLE_DEPTH) begin
          r.status = bps_pkg::STATUS_INVALID_SIZE;
        end else if (playing) begin
          r.status = bps_pkg::STATUS_BUSY;
        end else begin
          playing   = 1'b1;
          seq_len   = w.sound_count;
          seq_pos   = '0;
          pin_level = 1'b0;
          prescale  = '0;
          ms_left   = '0;
        end
      end
      bps_pkg::CMD_STOP: begin
        pin_level = 1'b0;
        playing   = 1'b0;
        prescale  = '0;
        ms_left   = '0;
      end
      default: begin
      end
    endcase
    r.buzzer_on     = pin_level;
    r.busy_res      = playing;
    r.current_sound = seq_pos;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic bps_pkg::word_t make_word(input logic [1:0] cmd,
                                               input logic [IDX_W-1:0] idx,
                                               input logic [MS_W-1:0] on_t,
                                               input logic [MS_W-1:0] off_t,
                                               input logic [4:0] cnt);
    bps_pkg::word_t w;
    w.command     = cmd;
    w.entry_index = idx;
    w.buzz_ms     = on_t;
    w.quiet_ms    = off_t;
    w.sound_count = cnt;
    return w;
  endfunction

  // Tick with garbage in the unused fields
  function automatic bps_pkg::word_t random_tick();
    return make_word(bps_pkg::CMD_TICK, IDX_W'($urandom), MS_W'($urandom), MS_W'($urandom),
                     5'($urandom));
  endfunction

  // Mostly short durations so that lists finish, now and then a long one
  function automatic logic [MS_W-1:0] pick_ms();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return MS_W'($urandom_range(0, 2));
    if (r < 95) return MS_W'($urandom_range(3, 12));
    return MS_W'($urandom);
  endfunction

  // Offer one word, hold it until accepted, then idle for a random gap
  task automatic send_word(input bps_pkg::word_t w);
    int gap;
    int r;
    in_valid    <= 1'b1;
    command     <= w.command;
    entry_index <= w.entry_index;
    buzz_ms     <= w.buzz_ms;
    quiet_ms    <= w.quiet_ms;
    sound_count <= w.sound_count;
    do @(posedge clk); while (in_ready !== 1'b1);
    due_results.push_back(advance_sequencer(w));
    words_sent++;
    r = $urandom_range(0, 99);
    if (steady_in || r < 65) gap = 0;
    else if (r < 92) gap = $urandom_range(1, 3);
    else gap = $urandom_range(4, 24);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stop offering and wait until every expected result word has come back
  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // Write the divider register with the block idle
  task automatic write_divider(input logic [DIV_W-1:0] value);
    wait_for_results();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    divider = value;
    cfg_we <= 1'b0;
  endtask

  // Load a few slots, start a list, tick it through with some noise, stop if it runs long
  task automatic play_episode(input int budget);
    int             count;
    int             n;
    int             s;
    int             pick;
    bps_pkg::word_t w;
    pick = $urandom_range(0, 99);
    if (pick < 75) count = $urandom_range(1, 4);
    else if (pick < 93) count = $urandom_range(5, TABLE_DEPTH - 1);
    else count = TABLE_DEPTH;
    repeat ($urandom_range(0, 3))
      send_word(make_word(bps_pkg::CMD_WRITE, IDX_W'($urandom), pick_ms(), pick_ms(),
                          5'($urandom)));
    // never play a slot that was not written
    for (s = 0; s < count; s++) begin
      if (!tone_loaded[s])
        send_word(make_word(bps_pkg::CMD_WRITE, IDX_W'(s), pick_ms(), pick_ms(),
                            5'($urandom)));
    end
    send_word(make_word(bps_pkg::CMD_START, IDX_W'($urandom), MS_W'($urandom),
                        MS_W'($urandom), 5'(count)));
    n = 0;
    while (playing && n < budget) begin
      pick = $urandom_range(0, 99);
      if (pick < 3)
        w = make_word(bps_pkg::CMD_WRITE, IDX_W'($urandom), MS_W'($urandom),
                      MS_W'($urandom), 5'($urandom));
      else if (pick < 6)
        w = make_word(bps_pkg::CMD_START, IDX_W'($urandom), MS_W'($urandom),
                      MS_W'($urandom), 5'($urandom));
      else if (pick < 7)
        w = make_word(bps_pkg::CMD_STOP, IDX_W'($urandom), MS_W'($urandom),
                      MS_W'($urandom), 5'($urandom));
      else
        w = random_tick();
      send_word(w);
      n++;
    end
    if (playing)
      send_word(make_word(bps_pkg::CMD_STOP, IDX_W'($urandom), MS_W'($urandom),
                          MS_W'($urandom), 5'($urandom)));
    // some idle traffic between lists
    repeat ($urandom_range(0, 2)) begin
      pick = $urandom_range(0, 2);
      if (pick == 0)
        w = random_tick();
      else if (pick == 1)
        w = make_word(bps_pkg::CMD_STOP, IDX_W'($urandom), MS_W'($urandom),
                      MS_W'($urandom), 5'($urandom));
      else
        w = make_word(bps_pkg::CMD_START, IDX_W'($urandom), MS_W'($urandom),
                      MS_W'($urandom),
                      ($urandom_range(0, 1) == 0) ? 5'd0 : 5'($urandom_range(17, 31)));
      send_word(w);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Commands on an idle block at the reset divider
  task automatic test_idle_commands();
    send_word(make_word(bps_pkg::CMD_TICK, '0, '0, '0, '0));
    send_word(make_word(bps_pkg::CMD_STOP, '1, '1, '1, '1));
    send_word(make_word(bps_pkg::CMD_START, '0, '0, '0, 5'd0));
    send_word(make_word(bps_pkg::CMD_START, '0, '0, '0, 5'd17));
    send_word(make_word(bps_pkg::CMD_START, '1, '1, '1, 5'd31));
    send_word(make_word(bps_pkg::CMD_TICK, '1, '1, '1, '1));
  endtask

  // Zero durations, refusals while playing, the skipped last off phase, stop mid-sound
  task automatic test_play_rules();
    write_divider(DIV_W'(1));
    send_word(make_word(bps_pkg::CMD_WRITE, 4'd0, 16'd0, 16'd0, '0));
    send_word(make_word(bps_pkg::CMD_WRITE, 4'd15, 16'hFFFF, 16'hFFFF, '0));
    send_word(make_word(bps_pkg::CMD_WRITE, 4'd1, 16'd1, 16'd2, '0));
    send_word(make_word(bps_pkg::CMD_START, '0, '0, '0, 5'd2));
    send_word(make_word(bps_pkg::CMD_START, '0, '0, '0, 5'd2));
    send_word(make_word(bps_pkg::CMD_START, '0, '0, '0, 5'd0));
    send_word(make_word(bps_pkg::CMD_WRITE, 4'd3, 16'd9, 16'd9, '0));
    while (playing) send_word(make_word(bps_pkg::CMD_TICK, '0, '0, '0, '0));
    send_word(make_word(bps_pkg::CMD_WRITE, 4'd0, 16'hFFFF, 16'd7, '0));
    send_word(make_word(bps_pkg::CMD_START, '0, '0, '0, 5'd1));
    repeat (3) send_word(make_word(bps_pkg::CMD_TICK, '0, '0, '0, '0));
    send_word(make_word(bps_pkg::CMD_STOP, '0, '0, '0, '0));
    send_word(make_word(bps_pkg::CMD_TICK, '0, '0, '0, '0));
    send_word(make_word(bps_pkg::CMD_WRITE, 4'd0, 16'd1, 16'd1, '0));
  endtask

  // Random lists under a rotating divider, the extremes among the settings
  task automatic test_random_play();
    int               goal;
    int               episodes;
    logic [DIV_W-1:0] next_div;
    goal     = words_sent + RANDOM_WORDS;
    episodes = 0;
    while (words_sent < goal) begin
      if (episodes % 2 == 0) begin
        case ((episodes / 2) % 6)
          0:       next_div = DIV_W'(1);
          1:       next_div = '0;
          2:       next_div = '1;
          3:       next_div = DIV_W'(2);
          4:       next_div = DIV_W'(3);
          default: next_div = DIV_W'($urandom_range(1, 6));
        endcase
        write_divider(next_div);
      end
      steady_in  = ($urandom_range(0, 3) == 0);
      steady_out = ($urandom_range(0, 3) == 0);
      play_episode((divider > DIV_W'(100)) ? SLOW_BUDGET : PLAY_BUDGET);
      episodes++;
    end
    steady_in  = 1'b0;
    steady_out = 1'b0;
  endtask

  // Long output stall while ticks keep coming, then a full drain before going on
  task automatic test_output_backpressure();
    int s;
    write_divider(DIV_W'(2));
    for (s = 0; s < 4; s++)
      send_word(make_word(bps_pkg::CMD_WRITE, IDX_W'(s), 16'd6, 16'd4, '0));
    send_word(make_word(bps_pkg::CMD_START, '0, '0, '0, 5'd4));
    steady_in    = 1'b1;
    hold_out_req = 1'b1;
    repeat (40) send_word(random_tick());
    send_word(make_word(bps_pkg::CMD_STOP, '0, '0, '0, '0));
    steady_in = 1'b0;
    wait_for_results();
    repeat (4) send_word(random_tick());
  endtask

  // ---------------------------------------------------------------------------
  // Receiver, checker, watchdog
  // ---------------------------------------------------------------------------

  // Drive out_ready: random stalls, quiet stretches, and one long hold on request
  always @(posedge clk) begin
    if (hold_out_req) begin
      hold_out_req = 1'b0;
      rx_stall     = LONG_HOLD;
    end
    if (rx_stall > 0) begin
      out_ready <= 1'b0;
      rx_stall--;
    end else if (steady_out || $urandom_range(0, 99) < 70) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= 1'b0;
      rx_stall = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 2) : $urandom_range(5, 30);
    end
  end

  task automatic report_mismatch(input string field, input logic [7:0] got,
                                 input logic [7:0] want);
    $display("ERROR: result %0d %s: got %0h, expected %0h", results_seen, field, got, want);
    errors++;
  endtask

  // Compare each accepted result word with the oldest expectation
  always @(posedge clk) begin : check_results
    bps_pkg::result_t want;
    if (!rst && out_valid === 1'b1 && out_ready) begin
      if (due_results.size() == 0) begin
        report_mismatch("unexpected word", {6'd0, status}, '0);
      end else begin
        want = due_results.pop_front();
        if (status !== want.status)
          report_mismatch("status", {6'd0, status}, {6'd0, want.status});
        if (buzzer_on !== want.buzzer_on)
          report_mismatch("buzzer_on", {7'd0, buzzer_on}, {7'd0, want.buzzer_on});
        if (busy_res !== want.busy_res)
          report_mismatch("busy_res", {7'd0, busy_res}, {7'd0, want.busy_res});
        if (current_sound !== want.current_sound)
          report_mismatch("current_sound", 8'(current_sound), 8'(want.current_sound));
      end
      results_seen++;
    end
  end

  // End the run when no word moves on either side for too long
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("ERROR: no word accepted for %0d cycles, %0d results outstanding",
                 idle_cycles, due_results.size());
        $display("Verification failed");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst          = 1'b1;
    cfg_we       = 1'b0;
    cfg_wdata    = '0;
    in_valid     = 1'b0;
    command      = '0;
    entry_index  = '0;
    buzz_ms      = '0;
    quiet_ms     = '0;
    sound_count  = '0;
    out_ready    = 1'b0;
    words_sent   = 0;
    results_seen = 0;
    errors       = 0;
    idle_cycles  = 0;
    rx_stall     = 0;
    steady_in    = 1'b0;
    steady_out   = 1'b0;
    hold_out_req = 1'b0;
    tone_loaded  = '0;
    seq_len      = '0;
    seq_pos      = '0;
    pin_level    = 1'b0;
    playing      = 1'b0;
    prescale     = '0;
    ms_left      = '0;
    divider      = bps_pkg::DIV_RESET;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    test_idle_commands();
    test_play_rules();
    test_random_play();
    test_output_backpressure();

    wait_for_results();
    repeat (8) @(posedge clk);
    if (errors == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
